// File: rtl/pas_pkg.sv
// Shared constants and types for the paren alignment scanner.
package pas_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int COLUMN_BITS = 12;
  localparam int ALIGN_BITS  = 12;
  localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);

  typedef logic [COLUMN_BITS-1:0] col_t;
  typedef logic [COUNT_BITS-1:0]  cnt_t;
  typedef logic [ALIGN_BITS-1:0]  align_t;

  localparam col_t COL_MAX = '1;

  // item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // characters of interest
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_REPL
  } stack_op_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    logic        new_statement;
  } in_item_t;

  typedef struct packed {
    logic        open_bracket;
    align_t      align_column;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic        clear;
    stack_op_t   op;
    col_t        data;
  } stack_cmd_t;

  typedef struct packed {
    cnt_t        count;
    col_t        below_top;
  } stack_stat_t;

endpackage

// File: rtl/pas_cell.sv
// One entry of the column stack; shifts down on push, up on pop; on replace only the lead (top) cell loads.
module pas_cell (
  input  logic                clk,
  input  pas_pkg::stack_op_t  op,
  input  logic                lead,
  input  pas_pkg::col_t       shift_in,
  input  pas_pkg::col_t       shift_up,
  output pas_pkg::col_t       value
);

  always_ff @(posedge clk) begin
    case (op)
      pas_pkg::OP_PUSH: value <= shift_in;
      pas_pkg::OP_POP:  value <= shift_up;
      pas_pkg::OP_REPL: begin
        if (lead) begin
          value <= shift_in;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/pas_stack.sv
// Column stack: a row of cells with the top at cell 0, plus the fill count.
module pas_stack (
  input  logic                  clk,
  input  logic                  rst,
  input  pas_pkg::stack_cmd_t   cmd,
  output pas_pkg::stack_stat_t  stat
);

  pas_pkg::col_t vals [pas_pkg::STACK_DEPTH];
  pas_pkg::cnt_t count;
  pas_pkg::cnt_t count_base;
  pas_pkg::cnt_t count_next;

  for (genvar i = 0; i < pas_pkg::STACK_DEPTH; i++) begin : g_cell
    pas_pkg::col_t shift_in;
    pas_pkg::col_t shift_up;
    if (i == 0) begin : g_head
      assign shift_in = cmd.data;
    end else begin : g_body
      assign shift_in = vals[i-1];
    end
    if (i == pas_pkg::STACK_DEPTH - 1) begin : g_tail
      assign shift_up = vals[i];
    end else begin : g_mid
      assign shift_up = vals[i+1];
    end
    pas_cell u_cell (
      .clk      (clk),
      .op       (cmd.op),
      .lead     ((i == 0) ? 1'b1 : 1'b0),
      .shift_in (shift_in),
      .shift_up (shift_up),
      .value    (vals[i])
    );
  end

  always_comb begin
    count_base = cmd.clear ? '0 : count;
    count_next = count_base;
    case (cmd.op)
      pas_pkg::OP_PUSH: count_next = count_base + pas_pkg::cnt_t'(1);
      pas_pkg::OP_POP:  count_next = count_base - pas_pkg::cnt_t'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign stat.count     = count;
  assign stat.below_top = vals[1];

endmodule

// File: rtl/paren_alignment_scanner_unit.sv
// Paren alignment scanner top level: scan control, stack, output skid buffer.
// Throughput: one item per cycle while in_stall is low (skid slot empty); characters and end-of-line items alike.
// An end-of-line item's result is registered into out_item, or into the skid slot
// when out_item is held by out_stall.
// Reset (rst, synchronous): clears scan state, stack count, start indent and
// both output slots; stack cells are not cleared and never read before write.
module paren_alignment_scanner_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pas_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output pas_pkg::out_item_t  out_item
);

  typedef enum logic [1:0] {
    MODE_OUT,
    MODE_QUOTE,
    MODE_OPEN,
    MODE_INSIDE
  } mode_t;

  function automatic pas_pkg::col_t sat_add(pas_pkg::col_t a, pas_pkg::col_t b);
    logic [pas_pkg::COLUMN_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[pas_pkg::COLUMN_BITS] ? pas_pkg::COL_MAX : s[pas_pkg::COLUMN_BITS-1:0];
  endfunction

  // clamp to the result field width
  function automatic pas_pkg::align_t sat_out(pas_pkg::col_t c);
    logic [15:0] w;
    w = 16'(c);
    return (w > 16'((1 << pas_pkg::ALIGN_BITS) - 1)) ? '1 : w[pas_pkg::ALIGN_BITS-1:0];
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == pas_pkg::CH_SPACE) || ((c >= pas_pkg::CH_TAB) && (c <= pas_pkg::CH_CR));
  endfunction

  // scan state
  mode_t         scan_mode, scan_mode_next;
  mode_t         return_mode, return_mode_next;
  logic [7:0]    quote_char, quote_char_next;
  pas_pkg::col_t indent_col, indent_col_next;
  pas_pkg::col_t line_base, line_base_next;
  pas_pkg::col_t start_indent, start_indent_next;
  pas_pkg::col_t column, column_next;
  logic          in_comment, in_comment_next;
  logic          first_line, first_line_next;
  logic          seen_nonblank, seen_nonblank_next;
  logic          overflow_flag, overflow_flag_next;

  // output slots: main register and skid
  pas_pkg::out_item_t skid_item;
  logic               skid_valid;

  pas_pkg::stack_cmd_t  cmd;
  pas_pkg::stack_stat_t stat;

  logic          accept;
  logic          ns;
  logic          is_quote, is_open, is_close;
  logic          do_push, do_pop, do_repl;
  logic          res_valid;
  pas_pkg::out_item_t res;

  // values after an optional new-statement clear
  mode_t         mode_e, ret_e;
  logic [7:0]    qc_e;
  pas_pkg::cnt_t cnt_e;
  pas_pkg::col_t cur_e, lb_e, col_e, pv, pop_cur;
  logic          cm_e, fl_e, sn_e, of_e;

  pas_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign ns       = in_item.new_statement;

  assign is_quote = (in_item.ch == pas_pkg::CH_DQUOTE) || (in_item.ch == pas_pkg::CH_SQUOTE);
  assign is_open  = (in_item.ch == pas_pkg::CH_LPAREN) || (in_item.ch == pas_pkg::CH_LBRACK);
  assign is_close = (in_item.ch == pas_pkg::CH_RPAREN) || (in_item.ch == pas_pkg::CH_RBRACK);

  always_comb begin
    mode_e = ns ? MODE_OUT : scan_mode;
    ret_e  = ns ? MODE_OUT : return_mode;
    qc_e   = ns ? 8'h00 : quote_char;
    cnt_e  = ns ? '0 : stat.count;
    cur_e  = ns ? '0 : indent_col;
    lb_e   = ns ? '0 : line_base;
    col_e  = ns ? '0 : column;
    cm_e   = ns ? 1'b0 : in_comment;
    fl_e   = ns ? 1'b1 : first_line;
    sn_e   = ns ? 1'b0 : seen_nonblank;
    of_e   = ns ? 1'b0 : overflow_flag;
    pv     = sat_add(lb_e, col_e);

    scan_mode_next     = scan_mode;
    return_mode_next   = return_mode;
    quote_char_next    = quote_char;
    indent_col_next    = indent_col;
    line_base_next     = line_base;
    start_indent_next  = start_indent;
    column_next        = column;
    in_comment_next    = in_comment;
    first_line_next    = first_line;
    seen_nonblank_next = seen_nonblank;
    overflow_flag_next = overflow_flag;

    cmd.clear = accept && ns;
    cmd.op    = pas_pkg::OP_HOLD;
    cmd.data  = pv;

    do_push   = 1'b0;
    do_pop    = 1'b0;
    do_repl   = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    pop_cur   = '0;

    if (accept) begin
      scan_mode_next     = mode_e;
      return_mode_next   = ret_e;
      quote_char_next    = qc_e;
      indent_col_next    = cur_e;
      line_base_next     = lb_e;
      column_next        = col_e;
      in_comment_next    = cm_e;
      first_line_next    = fl_e;
      seen_nonblank_next = sn_e;
      overflow_flag_next = of_e;

      if (in_item.kind == pas_pkg::KIND_CHAR) begin
        // statement indent: first non-space on the statement's first line
        if (fl_e && !sn_e && (in_item.ch != pas_pkg::CH_SPACE)) begin
          start_indent_next  = col_e;
          seen_nonblank_next = 1'b1;
        end
        column_next = (col_e == pas_pkg::COL_MAX) ? col_e : col_e + pas_pkg::col_t'(1);

        if (!cm_e) begin
          case (mode_e)
            MODE_OUT: begin
              if (is_quote) begin
                quote_char_next  = in_item.ch;
                return_mode_next = MODE_OUT;
                scan_mode_next   = MODE_QUOTE;
              end else if (is_open) begin
                do_push        = 1'b1;
                scan_mode_next = MODE_OPEN;
              end else if (in_item.ch == pas_pkg::CH_BANG) begin
                in_comment_next = 1'b1;
              end
            end
            MODE_QUOTE: begin
              if (is_quote && (in_item.ch == qc_e)) begin
                scan_mode_next = ret_e;
              end
            end
            MODE_OPEN: begin
              if (is_quote) begin
                do_repl          = 1'b1;
                quote_char_next  = in_item.ch;
                return_mode_next = MODE_INSIDE;
                scan_mode_next   = MODE_QUOTE;
              end else if (is_open) begin
                do_push        = 1'b1;
                scan_mode_next = MODE_OPEN;
              end else if (is_close) begin
                do_pop         = 1'b1;
                scan_mode_next = (cnt_e <= pas_pkg::cnt_t'(1)) ? MODE_OUT : MODE_OPEN;
              end else if (in_item.ch == pas_pkg::CH_BANG) begin
                in_comment_next = 1'b1;
              end else if ((in_item.ch != pas_pkg::CH_SLASH) && !is_blank(in_item.ch)) begin
                do_repl        = 1'b1;
                scan_mode_next = MODE_INSIDE;
              end
            end
            default: begin
              if (is_quote) begin
                quote_char_next  = in_item.ch;
                return_mode_next = MODE_INSIDE;
                scan_mode_next   = MODE_QUOTE;
              end else if (is_open) begin
                do_push        = 1'b1;
                scan_mode_next = MODE_OPEN;
              end else if (is_close) begin
                do_pop         = 1'b1;
                scan_mode_next = (cnt_e <= pas_pkg::cnt_t'(1)) ? MODE_OUT : MODE_INSIDE;
              end else if (in_item.ch == pas_pkg::CH_BANG) begin
                in_comment_next = 1'b1;
              end
            end
          endcase
        end

        // after a pop the top is the old second entry, or the statement indent
        pop_cur = (cnt_e > pas_pkg::cnt_t'(1)) ? stat.below_top : start_indent_next;

        if (do_push) begin
          indent_col_next = pv;
          if (cnt_e < pas_pkg::cnt_t'(pas_pkg::STACK_DEPTH)) begin
            cmd.op = pas_pkg::OP_PUSH;
          end else begin
            overflow_flag_next = 1'b1;
          end
        end
        if (do_pop && (cnt_e != '0)) begin
          cmd.op          = pas_pkg::OP_POP;
          indent_col_next = pop_cur;
        end
        if (do_repl) begin
          // pop then push: a plain push when the stack is empty
          indent_col_next = pv;
          cmd.op = (cnt_e == '0) ? pas_pkg::OP_PUSH : pas_pkg::OP_REPL;
        end
      end else begin
        line_base_next  = cur_e;
        column_next     = '0;
        in_comment_next = 1'b0;
        first_line_next = 1'b0;

        res_valid        = 1'b1;
        res.open_bracket = (cnt_e != '0);
        res.align_column = (cnt_e != '0) ? sat_out(cur_e) : '0;
        res.overflow     = of_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_OUT;
      return_mode   <= MODE_OUT;
      quote_char    <= 8'h00;
      indent_col    <= '0;
      line_base     <= '0;
      start_indent  <= '0;
      column        <= '0;
      in_comment    <= 1'b0;
      first_line    <= 1'b1;
      seen_nonblank <= 1'b0;
      overflow_flag <= 1'b0;
    end else begin
      scan_mode     <= scan_mode_next;
      return_mode   <= return_mode_next;
      quote_char    <= quote_char_next;
      indent_col    <= indent_col_next;
      line_base     <= line_base_next;
      start_indent  <= start_indent_next;
      column        <= column_next;
      in_comment    <= in_comment_next;
      first_line    <= first_line_next;
      seen_nonblank <= seen_nonblank_next;
      overflow_flag <= overflow_flag_next;
    end
  end

  // Output register with a skid slot: a new result lands in the skid only
  // when the main register is held; the skid then stalls the input.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        out_item   <= skid_item;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || !out_stall) begin
      out_valid <= res_valid;
      if (res_valid) begin
        out_item <= res;
      end
    end else if (res_valid) begin
      skid_item  <= res;
      skid_valid <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output register empty");

  a_mode_needs_entry: assert property (@(posedge clk) disable iff (rst)
    (scan_mode == MODE_OPEN || scan_mode == MODE_INSIDE) |-> stat.count != '0)
    else $error("inside brackets with an empty stack");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= pas_pkg::cnt_t'(pas_pkg::STACK_DEPTH))
    else $error("stack count past depth");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    (overflow_flag && !(accept && ns)) |=> overflow_flag)
    else $error("overflow flag dropped within a statement");

  a_closed_zero_col: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.open_bracket) |-> out_item.align_column == '0)
    else $error("align column set with no open bracket");
`endif

endmodule

// File: tb/paren_alignment_scanner_checker.sv
// Checker for the paren alignment scanner: predicts end-of-line results and compares them.
module paren_alignment_scanner_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  pas_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  pas_pkg::out_item_t out_item,
  output int                 mismatches,
  output int                 pending
);

  typedef enum logic [1:0] {
    SCAN_OUT,
    SCAN_QUOTE,
    SCAN_OPEN,
    SCAN_INSIDE
  } scan_mode_t;

  scan_mode_t    mode;
  scan_mode_t    ret_mode;
  logic [7:0]    quote_ch;
  pas_pkg::col_t col_stack [pas_pkg::STACK_DEPTH];
  int            depth;
  pas_pkg::col_t indent_col;
  pas_pkg::col_t line_base;
  pas_pkg::col_t start_indent;
  pas_pkg::col_t column;
  logic          in_comment;
  logic          first_line;
  logic          seen_nonblank;
  logic          ovf;

  pas_pkg::out_item_t align_q [$];
  pas_pkg::out_item_t want;
  int                 err_cnt = 0;

  function automatic pas_pkg::col_t sat_sum(pas_pkg::col_t a, pas_pkg::col_t b);
    logic [pas_pkg::COLUMN_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, pas_pkg::COL_MAX}) ? pas_pkg::COL_MAX : s[pas_pkg::COLUMN_BITS-1:0];
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == pas_pkg::CH_SPACE) || (c >= pas_pkg::CH_TAB && c <= pas_pkg::CH_CR);
  endfunction

  task automatic push_column();
    indent_col = sat_sum(line_base, column);
    if (depth >= pas_pkg::STACK_DEPTH) begin
      ovf = 1'b1;
    end else begin
      col_stack[depth] = indent_col;
      depth++;
    end
  endtask

  task automatic pop_column();
    if (depth == 0) return;
    depth--;
    indent_col = (depth > 0) ? col_stack[depth-1] : start_indent;
  endtask

  task automatic clear_statement();
    mode          = SCAN_OUT;
    ret_mode      = SCAN_OUT;
    quote_ch      = '0;
    depth         = 0;
    indent_col    = '0;
    line_base     = '0;
    column        = '0;
    in_comment    = 1'b0;
    first_line    = 1'b1;
    seen_nonblank = 1'b0;
    ovf           = 1'b0;
  endtask

  task automatic scan_byte(logic [7:0] c);
    logic is_q;
    logic is_op;
    logic is_cl;
    is_q  = (c == pas_pkg::CH_DQUOTE) || (c == pas_pkg::CH_SQUOTE);
    is_op = (c == pas_pkg::CH_LPAREN) || (c == pas_pkg::CH_LBRACK);
    is_cl = (c == pas_pkg::CH_RPAREN) || (c == pas_pkg::CH_RBRACK);
    if (first_line && !seen_nonblank && c != pas_pkg::CH_SPACE) begin
      start_indent  = column;
      seen_nonblank = 1'b1;
    end
    if (in_comment) return;
    case (mode)
      SCAN_OUT: begin
        if (is_q) begin
          quote_ch = c;
          ret_mode = SCAN_OUT;
          mode     = SCAN_QUOTE;
        end else if (is_op) begin
          push_column();
          mode = SCAN_OPEN;
        end else if (c == pas_pkg::CH_BANG) begin
          in_comment = 1'b1;
        end
      end
      SCAN_QUOTE: begin
        if (is_q && c == quote_ch) mode = ret_mode;
      end
      SCAN_OPEN: begin
        if (is_q) begin
          pop_column();
          push_column();
          quote_ch = c;
          ret_mode = SCAN_INSIDE;
          mode     = SCAN_QUOTE;
        end else if (is_op) begin
          push_column();
          mode = SCAN_OPEN;
        end else if (is_cl) begin
          pop_column();
          mode = (depth == 0) ? SCAN_OUT : SCAN_OPEN;
        end else if (c == pas_pkg::CH_BANG) begin
          in_comment = 1'b1;
        end else if (c != pas_pkg::CH_SLASH && !is_blank(c)) begin
          // first real character after the bracket sets the column
          pop_column();
          push_column();
          mode = SCAN_INSIDE;
        end
      end
      default: begin
        if (is_q) begin
          quote_ch = c;
          ret_mode = SCAN_INSIDE;
          mode     = SCAN_QUOTE;
        end else if (is_op) begin
          push_column();
          mode = SCAN_OPEN;
        end else if (is_cl) begin
          pop_column();
          mode = (depth == 0) ? SCAN_OUT : SCAN_INSIDE;
        end else if (c == pas_pkg::CH_BANG) begin
          in_comment = 1'b1;
        end
      end
    endcase
  endtask

  task automatic predict_item(pas_pkg::in_item_t it);
    pas_pkg::out_item_t r;
    if (it.new_statement) clear_statement();
    if (it.kind == pas_pkg::KIND_CHAR) begin
      scan_byte(it.ch);
      if (column < pas_pkg::COL_MAX) column++;
    end else begin
      line_base  = indent_col;
      column     = '0;
      in_comment = 1'b0;
      first_line = 1'b0;
      r.open_bracket = (depth != 0);
      r.align_column = (depth != 0) ? indent_col : '0;
      r.overflow     = ovf;
      align_q.insert(align_q.size(), r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_statement();
      start_indent = '0;
      foreach (col_stack[i]) col_stack[i] = '0;
      align_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (align_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none, got open=%0b col=%0d ovf=%0b",
                   $time, out_item.open_bracket, out_item.align_column, out_item.overflow);
        end else begin
          want = align_q[0];
          align_q.delete(0);
          if (out_item.open_bracket !== want.open_bracket) begin
            err_cnt++;
            $display("%0t: open_bracket expected %0b, got %0b",
                     $time, want.open_bracket, out_item.open_bracket);
          end
          if (out_item.align_column !== want.align_column) begin
            err_cnt++;
            $display("%0t: align_column expected %0d, got %0d",
                     $time, want.align_column, out_item.align_column);
          end
          if (out_item.overflow !== want.overflow) begin
            err_cnt++;
            $display("%0t: overflow expected %0b, got %0b",
                     $time, want.overflow, out_item.overflow);
          end
        end
      end
      if (in_valid && !in_stall) predict_item(in_item);
    end
    mismatches <= err_cnt;
    pending    <= align_q.size();
  end

endmodule

// File: tb/tb_paren_alignment_scanner_unit.sv
// Testbench top for the paren alignment scanner: stimulus, stall patterns and verdict.
module tb_paren_alignment_scanner_unit;

  // generous bound for the watchdog on the slowest legal run
  localparam int CYCLE_LIMIT = 100000;
  localparam int RAND_ITEMS  = 380;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  pas_pkg::in_item_t  in_item   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  pas_pkg::out_item_t out_item;

  int mismatches;
  int pending;
  int cycle_cnt  = 0;
  int gap_max    = 10;   // upper bound of idle cycles per item, both sides
  int sent_items = 0;

  // 8-unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  paren_alignment_scanner_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  paren_alignment_scanner_checker scan_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: after each result is taken, stall for a random count of cycles.
  // Stall is raised before the next result shows up, so it can hit any phase.
  initial begin : result_side
    int w;
    forever begin
      w = $urandom_range(0, gap_max);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one item after a random gap and hold it until the block takes it.
  // Valid only drops when a gap is drawn, so it is never lowered and raised
  // in the same step.
  task automatic send_item(pas_pkg::in_item_t it);
    int g;
    g = $urandom_range(0, gap_max);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_char(logic [7:0] c, logic ns);
    pas_pkg::in_item_t it;
    it.kind          = pas_pkg::KIND_CHAR;
    it.ch            = c;
    it.new_statement = ns;
    send_item(it);
  endtask

  // end-of-line items carry a random don't-care byte
  task automatic send_eol(logic ns);
    pas_pkg::in_item_t it;
    it.kind          = pas_pkg::KIND_EOL;
    it.ch            = 8'($urandom_range(0, 255));
    it.new_statement = ns;
    send_item(it);
  endtask

  task automatic send_text(string s, logic ns_first);
    for (int i = 0; i < s.len(); i++) send_char(s[i], ns_first && (i == 0));
  endtask

  // Hold off the sender until every predicted result has been taken.
  // The first edge lets the checker count the last accepted item.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char(logic deep);
    int r;
    r = $urandom_range(0, 99);
    if (deep && r < 70) begin
      return ($urandom_range(0, 1) != 0) ? pas_pkg::CH_LPAREN : pas_pkg::CH_LBRACK;
    end
    if (r < 25) return 8'(8'h61 + $urandom_range(0, 25));   // lower-case letter
    if (r < 40) return pas_pkg::CH_SPACE;
    if (r < 50) return ($urandom_range(0, 1) != 0) ? pas_pkg::CH_LPAREN : pas_pkg::CH_LBRACK;
    if (r < 60) return ($urandom_range(0, 1) != 0) ? pas_pkg::CH_RPAREN : pas_pkg::CH_RBRACK;
    if (r < 68) return ($urandom_range(0, 1) != 0) ? pas_pkg::CH_DQUOTE : pas_pkg::CH_SQUOTE;
    if (r < 72) return pas_pkg::CH_BANG;
    if (r < 77) return pas_pkg::CH_SLASH;
    if (r < 82) return 8'($urandom_range(pas_pkg::CH_TAB, pas_pkg::CH_CR));  // other blanks
    return 8'($urandom_range(0, 255));
  endfunction

  // A statement of a few lines with random content; now and then a
  // stray new_statement mid-line or an extra line end as noise.
  task automatic random_statement();
    int   lines;
    int   len;
    logic deep;
    logic ns;
    lines = $urandom_range(1, 4);
    deep  = ($urandom_range(0, 9) == 0);
    ns    = 1'b1;
    for (int l = 0; l < lines; l++) begin
      len = deep ? $urandom_range(10, 22) : $urandom_range(0, 12);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 3) ns = 1'b1;
        if ($urandom_range(0, 99) < 2) send_eol(ns);
        else send_char(pick_char(deep), ns);
        ns = 1'b0;
      end
      send_eol(ns);
      ns = 1'b0;
    end
  endtask

  initial begin : stimulus
    int  rand_base;
    logic paused;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // leading blanks, '/' and a tab after the bracket, a quote taking the
    // column, then a close in the outside state that does nothing
    send_text("  (/\t\"x\"]", 1'b1);
    send_char(pas_pkg::CH_RPAREN, 1'b0);
    send_eol(1'b0);
    // high byte takes the column, then a comment hides an open bracket
    send_char(pas_pkg::CH_LBRACK, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("!(", 1'b0);
    send_eol(1'b0);
    // single-quoted string holding a high byte, then the last close
    send_char(pas_pkg::CH_SQUOTE, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(pas_pkg::CH_SQUOTE, 1'b0);
    send_char(pas_pkg::CH_RBRACK, 1'b0);
    send_eol(1'b0);
    // zero byte opening a statement, new statement mid-line and on a line end
    send_char(8'h00, 1'b1);
    send_char(pas_pkg::CH_LPAREN, 1'b1);
    send_eol(1'b1);

    wait_drained();

    rand_base = sent_items;
    paused    = 1'b0;
    while (sent_items - rand_base < RAND_ITEMS) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      random_statement();
      if (!paused && sent_items - rand_base >= RAND_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    gap_max = 10;

    wait_drained();
    // wait on for any stray outputs
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
